[design/fsk4_pkg.sv]
package fsk4_pkg;

  // Fixed-width fields and reset values of the configuration registers
  localparam int unsigned BASE_STEP_W = 32;
  localparam int unsigned SHIFT_STEP_W = 20;
  localparam int unsigned SYMBOL_W = 2;
  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [BASE_STEP_W-1:0] BASE_STEP_RESET = 32'd536431662;
  localparam logic [SHIFT_STEP_W-1:0] SHIFT_STEP_RESET = 20'd56;

  // Phase accumulator default width and sine table geometry
  localparam int unsigned PHASE_BITS_DEF = 32;
  localparam int unsigned TABLE_BITS = 10;
  localparam int unsigned QUAD_BITS = TABLE_BITS - 2;
  localparam int unsigned QUARTER = 1 << QUAD_BITS;
  localparam int unsigned MAG_W = 7;
  localparam logic [MAG_W-1:0] AMPLITUDE = 7'd127;

  localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_STEP  = 1'b0,
    CFG_SHIFT_STEP = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic                   en;
    cfg_idx_e               idx;
    logic [BASE_STEP_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic                  valid;
    logic [TABLE_BITS-1:0] idx;
  } phase_tap_t;

  typedef logic [QUARTER-1:0][MAG_W-1:0] sine_lut_t;

  // Unsigned Q62 product, truncated
  function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
    logic [127:0] prod;
    prod = 128'(a) * 128'(b);
    return prod[125:62];
  endfunction

  // |sin| * 127 truncated, for quadrant offset k below QUARTER.
  // Taylor series in Q62; terms beyond x^25 are far below the truncation step.
  function automatic logic [MAG_W-1:0] quarter_sine(int unsigned k);
    logic [127:0] ang;
    logic [63:0]  x;
    logic [63:0]  x2;
    logic [63:0]  term;
    logic [63:0]  sum;
    logic [71:0]  scaled;
    ang    = 128'(HALF_PI_Q62) * 128'(k);
    x      = ang[QUAD_BITS+63:QUAD_BITS];
    x2     = mul_q62(x, x);
    term   = x;
    sum    = x;
    term   = mul_q62(term, x2) / 64'd6;   sum = sum - term;
    term   = mul_q62(term, x2) / 64'd20;  sum = sum + term;
    term   = mul_q62(term, x2) / 64'd42;  sum = sum - term;
    term   = mul_q62(term, x2) / 64'd72;  sum = sum + term;
    term   = mul_q62(term, x2) / 64'd110; sum = sum - term;
    term   = mul_q62(term, x2) / 64'd156; sum = sum + term;
    term   = mul_q62(term, x2) / 64'd210; sum = sum - term;
    term   = mul_q62(term, x2) / 64'd272; sum = sum + term;
    term   = mul_q62(term, x2) / 64'd342; sum = sum - term;
    term   = mul_q62(term, x2) / 64'd420; sum = sum + term;
    term   = mul_q62(term, x2) / 64'd506; sum = sum - term;
    term   = mul_q62(term, x2) / 64'd600; sum = sum + term;
    scaled = 72'(sum >> 6) * 72'(AMPLITUDE);
    return scaled[62:56];
  endfunction

  function automatic sine_lut_t build_sine_lut();
    sine_lut_t lut;
    for (int unsigned k = 0; k < QUARTER; k++) begin
      lut[k] = quarter_sine(k);
    end
    return lut;
  endfunction

  // First quadrant of the sine, offsets 0 .. QUARTER-1; offset QUARTER is AMPLITUDE
  localparam sine_lut_t SINE_LUT = build_sine_lut();

endpackage

[design/fsk4_phase_acc.sv]
module fsk4_phase_acc #(
  parameter int unsigned PHASE_BITS = fsk4_pkg::PHASE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fsk4_pkg::cfg_wr_t                 cfg_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [fsk4_pkg::SYMBOL_W-1:0]     symbol_i,
  output fsk4_pkg::phase_tap_t              tap_o,
  input  logic                              tap_ready_i
);
  import fsk4_pkg::*;

  localparam int unsigned ADD_W = (PHASE_BITS > BASE_STEP_W) ? PHASE_BITS : BASE_STEP_W;

  logic [BASE_STEP_W-1:0]  base_step_q;
  logic [SHIFT_STEP_W-1:0] shift_step_q;
  logic [PHASE_BITS-1:0]   phase_q, phase_d;
  logic [SHIFT_STEP_W+1:0] tone_off;
  logic [ADD_W-1:0]        phase_sum;
  logic                    tap_valid_q;
  logic [TABLE_BITS-1:0]   tap_idx_q;
  logic                    fire;

  assign in_ready_o = !tap_valid_q || tap_ready_i;
  assign fire       = in_valid_i && in_ready_o;
  assign tap_o      = '{valid: tap_valid_q, idx: tap_idx_q};

  // symbol times shift_step as a small select
  always_comb begin
    case (symbol_i)
      2'd0:    tone_off = '0;
      2'd1:    tone_off = (SHIFT_STEP_W + 2)'(shift_step_q);
      2'd2:    tone_off = (SHIFT_STEP_W + 2)'(shift_step_q) << 1;
      2'd3:    tone_off = ((SHIFT_STEP_W + 2)'(shift_step_q) << 1)
                          + (SHIFT_STEP_W + 2)'(shift_step_q);
      default: tone_off = '0;
    endcase
  end

  assign phase_sum = ADD_W'(phase_q) + ADD_W'(base_step_q) + ADD_W'(tone_off);
  assign phase_d   = phase_sum[PHASE_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_step_q  <= BASE_STEP_RESET;
      shift_step_q <= SHIFT_STEP_RESET;
    end else if (cfg_i.en) begin
      case (cfg_i.idx)
        CFG_BASE_STEP:  base_step_q  <= cfg_i.data;
        CFG_SHIFT_STEP: shift_step_q <= cfg_i.data[SHIFT_STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      tap_valid_q <= 1'b0;
    end else if (fire) begin
      phase_q     <= phase_d;
      tap_valid_q <= 1'b1;
    end else if (tap_ready_i) begin
      tap_valid_q <= 1'b0;
    end
  end

  // Tap the top phase bits of the phase before the advance
  always_ff @(posedge clk_i) begin
    if (fire) begin
      tap_idx_q <= phase_q[PHASE_BITS-1 -: TABLE_BITS];
    end
  end

`ifndef SYNTHESIS
  a_phase_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(phase_q))
    else $error("phase moved without an accepted item");
`endif

endmodule

[design/fsk4_sine_out.sv]
module fsk4_sine_out (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fsk4_pkg::phase_tap_t          tap_i,
  output logic                          tap_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [fsk4_pkg::SAMPLE_W-1:0] sample_o
);
  import fsk4_pkg::*;

  logic [1:0]             quad;
  logic [QUAD_BITS-1:0]   offs;
  logic [QUAD_BITS-1:0]   lut_idx;
  logic                   at_peak;
  logic [MAG_W-1:0]       mag;
  logic [SAMPLE_W-1:0]    sample_d, sample_q;
  logic                   valid_q;
  logic                   load;

  assign quad    = tap_i.idx[TABLE_BITS-1 -: 2];
  assign offs    = tap_i.idx[QUAD_BITS-1:0];
  // Fold odd quadrants: Q - r, with r == 0 landing on the peak
  assign at_peak = quad[0] && (offs == '0);
  assign lut_idx = quad[0] ? (QUAD_BITS'(0) - offs) : offs;
  assign mag     = at_peak ? AMPLITUDE : SINE_LUT[lut_idx];
  assign sample_d = quad[1] ? (SAMPLE_W'(0) - SAMPLE_W'(mag)) : SAMPLE_W'(mag);

  assign tap_ready_o = !valid_q || out_ready_i;
  assign load        = tap_i.valid && tap_ready_o;
  assign out_valid_o = valid_q;
  assign sample_o    = sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (tap_ready_o) begin
      valid_q <= tap_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      sample_q <= sample_d;
    end
  end

`ifndef SYNTHESIS
  a_no_min_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (sample_q != 8'h80))
    else $error("sample outside the symmetric range");
  a_load_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(valid_q) |-> $past(tap_i.valid))
    else $error("result appeared without a tapped phase");
`endif

endmodule

[design/four_tone_fsk_sine_synthesizer_core.sv]
// A symbol transferred on s_axis is registered as a table index in stage one, then
// as a sample in the output register of stage two. Throughput: one symbol per clock;
// the phase add and the table lookup run every cycle while m_axis keeps taking samples.
// Reset (rst_ni low, asynchronous): phase accumulator to zero, base_step and
// shift_step to their defaults, the valid flags of both pipeline stages cleared (the second drives m_axis_tvalid).
module four_tone_fsk_sine_synthesizer_core #(
  parameter int unsigned PHASE_BITS = fsk4_pkg::PHASE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration writes, always taken
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [fsk4_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [fsk4_pkg::BASE_STEP_W-1:0] cfg_data_i,
  // symbol stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [1:0] symbol, [7:2] zero
  // sample stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata   // [7:0] sample
);
  import fsk4_pkg::*;

  cfg_wr_t             cfg_wr;
  phase_tap_t          tap;
  logic                tap_ready;
  logic [SAMPLE_W-1:0] sample;

  // Registers are plain flops: accept every write in the cycle it arrives.
  assign cfg_ready_o = 1'b1;
  assign cfg_wr.en   = cfg_valid_i;
  assign cfg_wr.idx  = cfg_idx_e'(cfg_index_i);
  assign cfg_wr.data = cfg_data_i;

  // Stage one: hold the accumulator, tap the top phase bits of each symbol
  // transfer and advance by base_step + symbol * shift_step. The phase runs
  // on across symbol changes.
  fsk4_phase_acc #(
    .PHASE_BITS (PHASE_BITS)
  ) u_phase_acc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_wr),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .symbol_i    (s_axis_tdata[SYMBOL_W-1:0]),
    .tap_o       (tap),
    .tap_ready_i (tap_ready)
  );

  // Stage two: fold the phase into the first quadrant, look up the quarter
  // sine table, restore the sign and hold the sample in the output register.
  fsk4_sine_out u_sine_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tap_i       (tap),
    .tap_ready_o (tap_ready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sample_o    (sample)
  );

  assign m_axis_tdata = sample;

`ifndef SYNTHESIS
  // An empty output register never blocks the input side
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output register");
`endif

endmodule
